// ===== rtl/orthonormal_frame_from_three_points_top_macros.svh =====
// Assertion macros for the orthonormal frame block and its checker
`ifndef ORTHONORMAL_FRAME_FROM_THREE_POINTS_TOP_MACROS_SVH
`define ORTHONORMAL_FRAME_FROM_THREE_POINTS_TOP_MACROS_SVH

// check on every clock edge outside reset
`define OFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define OFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ofp_pkg.sv =====
// Types, widths and rounding functions shared by the orthonormal frame block
package ofp_pkg;

  localparam int CW        = 32;
  localparam int VW        = 33;
  localparam int NW        = 30;
  localparam int SW        = 62;
  localparam int RTW       = 63;
  localparam int LW        = 31;
  localparam int DRW       = 61;
  localparam int UW        = 32;
  localparam int INT_FRAC  = 30;
  localparam int OW        = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int MAGW      = 33;
  localparam int PW_W      = 6;

  localparam int OUT_SH    = INT_FRAC - OUT_FRAC_BITS;
  localparam longint OUT_HALF = (OUT_SH > 0) ? (64'sd1 <<< (OUT_SH - 1)) : 64'sd0;
  localparam longint OUT_ONE  = 64'sd1 <<< OUT_FRAC_BITS;
  localparam longint POS_LIM  = (OUT_ONE > 32767) ? 32767 : OUT_ONE;
  localparam longint NEG_LIM  = (OUT_ONE > 32768) ? 32768 : OUT_ONE;

  typedef logic signed [VW-1:0] vcomp_t;
  typedef vcomp_t [2:0]          vvec_t;
  typedef logic signed [UW-1:0] ucomp_t;
  typedef ucomp_t [2:0]          uvec_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } ustat_t;

  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'(1) << (INT_FRAC - 1))) >> INT_FRAC;
    return v[65] ? -$signed(r[35:0]) : $signed(r[35:0]);
  endfunction

  function automatic logic [OW-1:0] to_out(input logic signed [35:0] v);
    logic [35:0] m;
    logic [35:0] r;
    logic [35:0] lim;
    m   = v[35] ? 36'(-v) : 36'(v);
    r   = (m + 36'(OUT_HALF)) >> OUT_SH;
    lim = v[35] ? 36'(NEG_LIM) : 36'(POS_LIM);
    if (r > lim) begin
      r = lim;
    end
    return v[35] ? OW'(-r) : OW'(r);
  endfunction

endpackage

// ===== rtl/ofp_sqrt_cell.sv =====
// One restoring step of the square root chain
module ofp_sqrt_cell #(
  parameter int K  = 0,
  parameter int AW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic [ofp_pkg::RTW-1:0]  rem_i,
  input  logic [ofp_pkg::LW-1:0]   root_i,
  input  logic [AW-1:0]            aux_i,
  output logic                     vld_o,
  output logic [ofp_pkg::RTW-1:0]  rem_o,
  output logic [ofp_pkg::LW-1:0]   root_o,
  output logic [AW-1:0]            aux_o
);

  logic [ofp_pkg::RTW-1:0] t;
  logic                    vld_r;
  logic [ofp_pkg::RTW-1:0] rem_r;
  logic [ofp_pkg::LW-1:0]  root_r;
  logic [AW-1:0]           aux_r;

  assign t = (ofp_pkg::RTW'(root_i) << (K + 1)) + (ofp_pkg::RTW'(1) << (2 * K));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aux_r <= aux_i;
      if (rem_i >= t) begin
        rem_r  <= rem_i - t;
        root_r <= root_i | (ofp_pkg::LW'(1) << K);
      end else begin
        rem_r  <= rem_i;
        root_r <= root_i;
      end
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign aux_o  = aux_r;

endmodule

// ===== rtl/ofp_div_cell.sv =====
// One restoring step of the three-lane division chain
module ofp_div_cell #(
  parameter int K  = 0,
  parameter int AW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic [ofp_pkg::LW-1:0]            len_i,
  input  logic [2:0][ofp_pkg::DRW-1:0]      rem_i,
  input  logic [2:0][ofp_pkg::LW-1:0]       q_i,
  input  logic [AW-1:0]                     aux_i,
  output logic                              vld_o,
  output logic [ofp_pkg::LW-1:0]            len_o,
  output logic [2:0][ofp_pkg::DRW-1:0]      rem_o,
  output logic [2:0][ofp_pkg::LW-1:0]       q_o,
  output logic [AW-1:0]                     aux_o
);

  logic [ofp_pkg::DRW-1:0]         d;
  logic                            vld_r;
  logic [ofp_pkg::LW-1:0]          len_r;
  logic [2:0][ofp_pkg::DRW-1:0]    rem_r;
  logic [2:0][ofp_pkg::LW-1:0]     q_r;
  logic [AW-1:0]                   aux_r;

  assign d = ofp_pkg::DRW'(len_i) << K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_i;
      aux_r <= aux_i;
      for (int i = 0; i < 3; i++) begin
        if (rem_i[i] >= d) begin
          rem_r[i] <= rem_i[i] - d;
          q_r[i]   <= q_i[i] | (ofp_pkg::LW'(1) << K);
        end else begin
          rem_r[i] <= rem_i[i];
          q_r[i]   <= q_i[i];
        end
      end
    end
  end

  assign vld_o = vld_r;
  assign len_o = len_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign aux_o = aux_r;

endmodule

// ===== rtl/ofp_unit.sv =====
// Unit vector pipeline: scale, square sum, square root chain, division chain
module ofp_unit #(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  ofp_pkg::vvec_t    v_i,
  input  logic [PW-1:0]     side_i,
  output ofp_pkg::ustat_t   stat_o,
  output ofp_pkg::uvec_t    u_o,
  output logic [PW-1:0]     side_o
);

  localparam int NW  = ofp_pkg::NW;
  localparam int LW  = ofp_pkg::LW;
  localparam int SAW = PW + 4 + 3 * NW;
  localparam int DAW = PW + 4;

  logic [2:0][ofp_pkg::MAGW-1:0] mag;
  logic [ofp_pkg::MAGW-1:0]      mx;
  logic [ofp_pkg::PW_W-1:0]      p;

  logic                          s1_vld_r;
  logic [2:0][ofp_pkg::MAGW-1:0] s1_mag_r;
  logic [2:0]                    s1_sgn_r;
  logic [ofp_pkg::PW_W-1:0]      s1_p_r;
  logic                          s1_zero_r;
  logic [PW-1:0]                 s1_side_r;

  logic [2:0][NW-1:0]            nm_nxt;
  logic                          s2_vld_r;
  logic [2:0][NW-1:0]            s2_nm_r;
  logic [2:0]                    s2_sgn_r;
  logic                          s2_zero_r;
  logic [PW-1:0]                 s2_side_r;

  logic                          s3_vld_r;
  logic [2:0][2*NW-1:0]          s3_sq_r;
  logic [2:0][NW-1:0]            s3_nm_r;
  logic [2:0]                    s3_sgn_r;
  logic                          s3_zero_r;
  logic [PW-1:0]                 s3_side_r;

  logic                          s4_vld_r;
  logic [ofp_pkg::SW-1:0]        s4_sum_r;
  logic [SAW-1:0]                s4_aux_r;

  logic                          sq_vld  [0:LW];
  logic [ofp_pkg::RTW-1:0]       sq_rem  [0:LW];
  logic [LW-1:0]                 sq_root [0:LW];
  logic [SAW-1:0]                sq_aux  [0:LW];

  logic                          dv_vld  [0:LW];
  logic [LW-1:0]                 dv_len  [0:LW];
  logic [2:0][ofp_pkg::DRW-1:0]  dv_rem  [0:LW];
  logic [2:0][LW-1:0]            dv_q    [0:LW];
  logic [DAW-1:0]                dv_aux  [0:LW];

  logic [2:0][NW-1:0]            dm;
  logic [2:0]                    osgn;

  always_comb begin
    mx = '0;
    p  = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v_i[i][ofp_pkg::VW-1] ? ofp_pkg::MAGW'(-v_i[i]) : ofp_pkg::MAGW'(v_i[i]);
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end
    for (int b = 0; b < ofp_pkg::MAGW; b++) begin
      if (mx[b]) begin
        p = ofp_pkg::PW_W'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1_p_r > ofp_pkg::PW_W'(NW - 1)) begin
        nm_nxt[i] = NW'(s1_mag_r[i] >> (s1_p_r - ofp_pkg::PW_W'(NW - 1)));
      end else begin
        nm_nxt[i] = NW'(s1_mag_r[i] << (ofp_pkg::PW_W'(NW - 1) - s1_p_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= mag;
      s1_sgn_r  <= {v_i[2][ofp_pkg::VW-1], v_i[1][ofp_pkg::VW-1], v_i[0][ofp_pkg::VW-1]};
      s1_p_r    <= p;
      s1_zero_r <= (mx == '0);
      s1_side_r <= side_i;

      s2_nm_r   <= nm_nxt;
      s2_sgn_r  <= s1_sgn_r;
      s2_zero_r <= s1_zero_r;
      s2_side_r <= s1_side_r;

      for (int i = 0; i < 3; i++) begin
        s3_sq_r[i] <= (2*NW)'(s2_nm_r[i]) * (2*NW)'(s2_nm_r[i]);
      end
      s3_nm_r   <= s2_nm_r;
      s3_sgn_r  <= s2_sgn_r;
      s3_zero_r <= s2_zero_r;
      s3_side_r <= s2_side_r;

      s4_sum_r  <= ofp_pkg::SW'(s3_sq_r[0]) + ofp_pkg::SW'(s3_sq_r[1])
                 + ofp_pkg::SW'(s3_sq_r[2]);
      s4_aux_r  <= {s3_side_r, s3_zero_r, s3_sgn_r, s3_nm_r};
    end
  end

  assign sq_vld[0]  = s4_vld_r;
  assign sq_rem[0]  = ofp_pkg::RTW'(s4_sum_r);
  assign sq_root[0] = '0;
  assign sq_aux[0]  = s4_aux_r;

  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    ofp_sqrt_cell #(.K(LW - 1 - j), .AW(SAW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .aux_i  (sq_aux[j]),
      .vld_o  (sq_vld[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .aux_o  (sq_aux[j+1])
    );
  end

  assign dm = sq_aux[LW][3*NW-1:0];

  for (genvar i = 0; i < 3; i++) begin : g_dv_init
    assign dv_rem[0][i] = (ofp_pkg::DRW'(dm[i]) << ofp_pkg::INT_FRAC)
                        + ofp_pkg::DRW'(sq_root[LW] >> 1);
  end

  assign dv_q[0]   = '0;
  assign dv_vld[0] = sq_vld[LW];
  assign dv_len[0] = sq_root[LW];
  assign dv_aux[0] = sq_aux[LW][SAW-1:3*NW];

  for (genvar j = 0; j < LW; j++) begin : g_div
    ofp_div_cell #(.K(LW - 1 - j), .AW(DAW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_vld[j]),
      .len_i (dv_len[j]),
      .rem_i (dv_rem[j]),
      .q_i   (dv_q[j]),
      .aux_i (dv_aux[j]),
      .vld_o (dv_vld[j+1]),
      .len_o (dv_len[j+1]),
      .rem_o (dv_rem[j+1]),
      .q_o   (dv_q[j+1]),
      .aux_o (dv_aux[j+1])
    );
  end

  assign osgn = dv_aux[LW][2:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_o[i] = osgn[i] ? -ofp_pkg::UW'(dv_q[LW][i]) : ofp_pkg::UW'(dv_q[LW][i]);
    end
  end

  assign stat_o.vld  = dv_vld[LW];
  assign stat_o.zero = dv_aux[LW][3];
  assign side_o      = dv_aux[LW][DAW-1:4];

endmodule

// ===== rtl/orthonormal_frame_from_three_points_top.sv =====
// Orthonormal frame from three points: top level with the frame pipeline
// Frame path: two unit vector pipelines in series, each a 31-cell square root chain
// and a 31-cell division chain.
// Throughput: one point triple per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active low; clears every valid flag, no memory to clear.
module orthonormal_frame_from_three_points_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
  output logic [143:0] out_tdata,
  // degenerate
  output logic         out_tuser
);

  localparam int CW = ofp_pkg::CW;
  localparam int UW = ofp_pkg::UW;
  localparam int OW = ofp_pkg::OW;
  localparam int WPW = 1 + 3 * UW;

  logic                    en;
  logic                    t0_vld_r;
  ofp_pkg::vvec_t          t0_da_r;
  ofp_pkg::vvec_t          t0_db_r;
  ofp_pkg::vvec_t          da_nxt;
  ofp_pkg::vvec_t          db_nxt;

  ofp_pkg::ustat_t         sta_a;
  ofp_pkg::ustat_t         sta_b;
  ofp_pkg::ustat_t         sta_w;
  ofp_pkg::uvec_t          ua;
  ofp_pkg::uvec_t          ub;
  ofp_pkg::uvec_t          uw;
  logic [WPW-1:0]          w_side;

  logic                    t1_vld_r;
  logic signed [63:0]      t1_pa_r [3];
  ofp_pkg::uvec_t          t1_a_r;
  ofp_pkg::uvec_t          t1_b_r;
  logic                    t1_deg_r;

  logic                    t2_vld_r;
  logic signed [33:0]      t2_dot_r;
  ofp_pkg::uvec_t          t2_a_r;
  ofp_pkg::uvec_t          t2_b_r;
  logic                    t2_deg_r;

  logic                    t3_vld_r;
  logic signed [65:0]      t3_pd_r [3];
  ofp_pkg::uvec_t          t3_a_r;
  ofp_pkg::uvec_t          t3_b_r;
  logic                    t3_deg_r;

  logic                    t4_vld_r;
  ofp_pkg::vvec_t          t4_w_r;
  ofp_pkg::uvec_t          t4_b_r;
  logic                    t4_deg_r;

  ofp_pkg::uvec_t          wb;
  logic                    t5_vld_r;
  logic signed [63:0]      t5_x_r [3];
  logic signed [63:0]      t5_y_r [3];
  ofp_pkg::uvec_t          t5_a_r;
  ofp_pkg::uvec_t          t5_b_r;
  logic                    t5_deg_r;

  logic signed [35:0]      c_nxt [3];
  logic [143:0]            out_tdata_nxt;
  logic                    out_tvalid_r;
  logic [143:0]            out_tdata_r;
  logic                    out_tuser_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da_nxt[i] = ofp_pkg::VW'($signed(in_tdata[CW*(6+i) +: CW]))
                - ofp_pkg::VW'($signed(in_tdata[CW*(3+i) +: CW]));
      db_nxt[i] = ofp_pkg::VW'($signed(in_tdata[CW*i +: CW]))
                - ofp_pkg::VW'($signed(in_tdata[CW*(3+i) +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r     <= 1'b0;
      t1_vld_r     <= 1'b0;
      t2_vld_r     <= 1'b0;
      t3_vld_r     <= 1'b0;
      t4_vld_r     <= 1'b0;
      t5_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      t0_vld_r     <= in_tvalid;
      t1_vld_r     <= sta_a.vld;
      t2_vld_r     <= t1_vld_r;
      t3_vld_r     <= t2_vld_r;
      t4_vld_r     <= t3_vld_r;
      t5_vld_r     <= sta_w.vld;
      out_tvalid_r <= t5_vld_r;
    end
  end

  ofp_unit #(.PW(1)) u_unit_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (t0_vld_r),
    .v_i    (t0_da_r),
    .side_i (1'b0),
    .stat_o (sta_a),
    .u_o    (ua),
    .side_o ()
  );

  ofp_unit #(.PW(1)) u_unit_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (t0_vld_r),
    .v_i    (t0_db_r),
    .side_i (1'b0),
    .stat_o (sta_b),
    .u_o    (ub),
    .side_o ()
  );

  ofp_unit #(.PW(WPW)) u_unit_w (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (t4_vld_r),
    .v_i    (t4_w_r),
    .side_i ({t4_deg_r, t4_b_r}),
    .stat_o (sta_w),
    .u_o    (uw),
    .side_o (w_side)
  );

  assign wb = w_side[3*UW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = '0;
    end
    c_nxt[0] = ofp_pkg::rnd30(66'(t5_x_r[0]) - 66'(t5_y_r[0]));
    c_nxt[1] = ofp_pkg::rnd30(66'(t5_x_r[1]) - 66'(t5_y_r[1]));
    c_nxt[2] = ofp_pkg::rnd30(66'(t5_x_r[2]) - 66'(t5_y_r[2]));
    out_tdata_nxt = '0;
    if (!t5_deg_r) begin
      for (int i = 0; i < 3; i++) begin
        out_tdata_nxt[OW*i +: OW]     = ofp_pkg::to_out(36'($signed(t5_a_r[i])));
        out_tdata_nxt[OW*(3+i) +: OW] = ofp_pkg::to_out(36'($signed(t5_b_r[i])));
        out_tdata_nxt[OW*(6+i) +: OW] = ofp_pkg::to_out(c_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_da_r  <= da_nxt;
      t0_db_r  <= db_nxt;

      for (int i = 0; i < 3; i++) begin
        t1_pa_r[i] <= 64'($signed(ua[i])) * 64'($signed(ub[i]));
      end
      t1_a_r   <= ua;
      t1_b_r   <= ub;
      t1_deg_r <= sta_a.zero || sta_b.zero;

      t2_dot_r <= 34'(ofp_pkg::rnd30(66'(t1_pa_r[0]) + 66'(t1_pa_r[1]) + 66'(t1_pa_r[2])));
      t2_a_r   <= t1_a_r;
      t2_b_r   <= t1_b_r;
      t2_deg_r <= t1_deg_r;

      for (int i = 0; i < 3; i++) begin
        t3_pd_r[i] <= 66'(t2_dot_r) * 66'($signed(t2_b_r[i]));
      end
      t3_a_r   <= t2_a_r;
      t3_b_r   <= t2_b_r;
      t3_deg_r <= t2_deg_r;

      for (int i = 0; i < 3; i++) begin
        t4_w_r[i] <= ofp_pkg::VW'(36'($signed(t3_a_r[i])) - ofp_pkg::rnd30(t3_pd_r[i]));
      end
      t4_b_r   <= t3_b_r;
      t4_deg_r <= t3_deg_r;

      t5_x_r[0] <= 64'($signed(uw[1])) * 64'($signed(wb[2]));
      t5_y_r[0] <= 64'($signed(uw[2])) * 64'($signed(wb[1]));
      t5_x_r[1] <= 64'($signed(uw[2])) * 64'($signed(wb[0]));
      t5_y_r[1] <= 64'($signed(uw[0])) * 64'($signed(wb[2]));
      t5_x_r[2] <= 64'($signed(uw[0])) * 64'($signed(wb[1]));
      t5_y_r[2] <= 64'($signed(uw[1])) * 64'($signed(wb[0]));
      t5_a_r    <= uw;
      t5_b_r    <= wb;
      t5_deg_r  <= w_side[WPW-1] || sta_w.zero;

      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= t5_deg_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/ofp_checker.sv =====
// Port checker for the orthonormal frame block, bound to the top level
`include "orthonormal_frame_from_three_points_top_macros.svh"

module ofp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tuser
);

  `OFP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `OFP_ASSERT(a_deg_zero, out_tvalid && out_tuser |-> out_tdata == '0, "degenerate result not zero")
  `OFP_ASSERT(a_m00_range, out_tvalid && !out_tuser |-> $signed(out_tdata[15:0]) <= 16'sd16384 && $signed(out_tdata[15:0]) >= -16'sd16384, "m00 out of range")
  `OFP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind orthonormal_frame_from_three_points_top ofp_checker u_ofp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/orthonormal_frame_from_three_points_top_tb.sv =====
// Testbench for the orthonormal frame block: directed table, then random triples
`timescale 1ns / 1ps

module orthonormal_frame_from_three_points_top_tb;

  localparam int N_RANDOM   = 1000;
  localparam int LATENCY    = 139;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 16;

  typedef struct packed {
    logic [143:0] mat;
    logic         degen;
  } frame_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         out_tuser;

  frame_t  frames_due[$];
  int      mismatches;
  int      results_seen;
  int      cycles;
  bit      stim_done;
  bit      quiet_end;
  bit      long_hold;

  logic [287:0] dir_pts[N_DIRECTED];
  bit           dir_known[N_DIRECTED];
  frame_t       dir_frame[N_DIRECTED];

  orthonormal_frame_from_three_points_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] mag_of(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint round_drop(input longint v, input int s);
    logic [63:0] m;
    m = mag_of(v);
    if (s > 0) begin
      m = (m + (64'd1 << (s - 1))) >> s;
    end
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) begin
      bitv >>= 2;
    end
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit normalise(input longint v[3], output longint u[3]);
    logic [63:0] m[3];
    logic [63:0] mx;
    logic [63:0] sum;
    logic [63:0] len;
    logic [127:0] q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(v[i]);
      if (m[i] > mx) mx = m[i];
      u[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((128'(m[i]) << 30) + 128'(len >> 1)) / 128'(len);
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] to_q14(input longint v);
    longint r;
    r = round_drop(v, 30 - ofp_pkg::OUT_FRAC_BITS);
    if (r > ofp_pkg::POS_LIM) r = ofp_pkg::POS_LIM;
    if (r < -ofp_pkg::NEG_LIM) r = -ofp_pkg::NEG_LIM;
    return 16'(r);
  endfunction

  function automatic frame_t predict_frame(input logic [287:0] pts);
    longint da[3], db[3], a[3], b[3], w[3], c[3];
    longint dot;
    bit ok;
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      da[i] = longint'($signed(pts[32*(6+i) +: 32])) - longint'($signed(pts[32*(3+i) +: 32]));
      db[i] = longint'($signed(pts[32*i +: 32])) - longint'($signed(pts[32*(3+i) +: 32]));
    end
    ok = normalise(da, a);
    if (ok) ok = normalise(db, b);
    if (ok) begin
      dot = round_drop(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
      for (int i = 0; i < 3; i++) w[i] = a[i] - round_drop(dot * b[i], 30);
      ok = normalise(w, a);
    end
    f = '0;
    if (!ok) begin
      f.degen = 1'b1;
      return f;
    end
    c[0] = round_drop(a[1] * b[2] - a[2] * b[1], 30);
    c[1] = round_drop(a[2] * b[0] - a[0] * b[2], 30);
    c[2] = round_drop(a[0] * b[1] - a[1] * b[0], 30);
    for (int i = 0; i < 3; i++) begin
      f.mat[16*i +: 16]     = to_q14(a[i]);
      f.mat[16*(3+i) +: 16] = to_q14(b[i]);
      f.mat[16*(6+i) +: 16] = to_q14(c[i]);
    end
    return f;
  endfunction

  function automatic logic [287:0] pack_pts(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
    return {32'(z2), 32'(y2), 32'(x2), 32'(z1), 32'(y1), 32'(x1), 32'(z0), 32'(y0), 32'(x0)};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [287:0] rand_pts();
    logic [287:0] p;
    int k;
    for (int i = 0; i < 9; i++) p[32*i +: 32] = rand_coord();
    case ($urandom_range(0, 15))
      0: p[96 +: 96] = p[0 +: 96];
      1: p[192 +: 96] = p[96 +: 96];
      2: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) begin
          p[32*(6+i) +: 32] = p[32*(3+i) +: 32] + (p[32*i +: 32] - p[32*(3+i) +: 32]) * k;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_item(input logic [287:0] pts, input bit known, input frame_t f);
    int gap;
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= pts;
    in_tvalid <= 1'b1;
    frames_due.push_back(known ? f : predict_frame(pts));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    stim_done = 1'b0;
    quiet_end = 1'b0;
    long_hold = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_known[i] = 1'b0;
      dir_frame[i] = '0;
    end
    dir_pts[0]  = '0;
    dir_known[0] = 1'b1;
    dir_frame[0] = frame_t'({144'd0, 1'b1});
    dir_pts[1]  = pack_pts(0, 65536, 0, 0, 0, 0, 65536, 0, 0);
    dir_known[1] = 1'b1;
    dir_frame[1] = frame_t'({16'h4000, 16'd0, 16'd0, 16'd0, 16'h4000, 16'd0,
                             16'd0, 16'd0, 16'h4000, 1'b0});
    dir_pts[2]  = pack_pts(5, 6, 7, 5, 6, 7, 1, 2, 3);
    dir_known[2] = 1'b1;
    dir_frame[2] = frame_t'({144'd0, 1'b1});
    dir_pts[3]  = pack_pts(1, 2, 3, 0, 0, 0, 0, 0, 0);
    dir_known[3] = 1'b1;
    dir_frame[3] = frame_t'({144'd0, 1'b1});
    dir_pts[4]  = pack_pts(2, 2, 2, 0, 0, 0, -3, -3, -3);
    dir_pts[5]  = pack_pts(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    dir_pts[6]  = pack_pts(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    dir_pts[7]  = pack_pts(1, 0, 0, 0, 0, 0, 1000000, 1, 0);
    dir_pts[8]  = pack_pts(-1, -1, -1, 0, 0, 0, 1, -1, 1);
    dir_pts[9]  = pack_pts(-1, -1, -1, -1, -1, -1, 0, 0, 0);
    dir_known[9] = 1'b1;
    dir_frame[9] = frame_t'({144'd0, 1'b1});
    dir_pts[10] = pack_pts(0, 0, 1, 0, 0, 0, 0, 1, 0);
    dir_pts[11] = pack_pts(3, 4, 0, 0, 0, 0, 0, 0, -7);
    dir_pts[12] = pack_pts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    dir_pts[13] = pack_pts(100, 0, 0, 0, 0, 0, 100, 1, 0);
    dir_pts[14] = pack_pts(7, -9, 11, 2, 2, 2, -13, 17, 5);
    dir_pts[15] = pack_pts(65536, 65536, 0, 0, 0, 0, 0, 65536, 65536);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      push_item(dir_pts[i], dir_known[i], dir_frame[i]);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 4) long_hold = 1'b1;
      if (n == N_RANDOM - 150) quiet_end = 1'b1;
      push_item(rand_pts(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int hold;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet_end && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", out_tdata, out_tuser);
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_tdata[16*i +: 16] !== want.mat[16*i +: 16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d m%0d%0d: expected %h got %h", results_seen,
                       i / 3, i % 3, want.mat[16*i +: 16], out_tdata[16*i +: 16]);
          end
        end
        if (out_tuser !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d degenerate: expected %b got %b", results_seen,
                     want.degen, out_tuser);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d point triples sent (%0d directed), %0d frames checked, %0d mismatches",
             N_DIRECTED + N_RANDOM, N_DIRECTED, results_seen, mismatches);
    $display("coverage: coincident, collinear, extreme coords, long output stall");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== orthonormal_frame_from_three_points_top.f =====
+incdir+rtl
rtl/ofp_pkg.sv
rtl/ofp_sqrt_cell.sv
rtl/ofp_div_cell.sv
rtl/ofp_unit.sv
rtl/orthonormal_frame_from_three_points_top.sv
rtl/ofp_checker.sv
dv/orthonormal_frame_from_three_points_top_tb.sv
